### sv/linear_queue_with_aggregates_assert.svh
// assertion macros for the linear queue with aggregates
// included by the checker module; no other dependencies
`ifndef LINEAR_QUEUE_WITH_AGGREGATES_ASSERT_SVH
`define LINEAR_QUEUE_WITH_AGGREGATES_ASSERT_SVH

// same-cycle implication
`define LQA_ASSERT_IMPL(name, clk, dis, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LQA_ASSERT_NEXT(name, clk, dis, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lqa_pkg.sv
// shared types and constants for the linear queue with aggregates
// no dependencies
package lqa_pkg;

   localparam int DEPTH  = 128;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 8;
   localparam int OCC_W  = 8;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = ((DATA_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 4 * DATA_W + OCC_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK
   } lqa_state_type;

   // where popped value and product of a result come from
   typedef enum logic [1:0] {
      SRC_PLAIN,
      SRC_POP,
      SRC_ONE,
      SRC_PROD
   } lqa_src_type;

   typedef struct packed {
      logic              write_en;
      logic              pop_commit;
      logic              walk_init;
      logic              walk_step;
      logic              rd_walk;
      logic              out_load;
      logic [STAT_W-1:0] out_status;
      lqa_src_type       out_src;
   } lqa_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic walk_last;
   } lqa_stat_type;

endpackage

### sv/linear_queue_with_aggregates.sv
// top level of the linear queue with aggregates
// depends on lqa_pkg, lqa_ctrl, lqa_dp (and lqa_ram through lqa_dp)
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tuser command, tdata push value
//   rsp_      out        rsp_tvalid/rsp_tready  tuser status, tdata result fields
//   csr_      in         csr_we                 csr_wdata capacity
//
// push and an unused command: results registered at the transfer edge
// pop: result loaded from the registered read of the slot store
// report: on an empty queue registered at the transfer edge, else a walk over
//   the entries left, as the single store read port feeds one multiply per cycle
// synchronous reset clears counters and sums and sets capacity to 100;
//   the slot store is not cleared
// one item in flight: a result waiting in the output register holds off req_tready
module linear_queue_with_aggregates (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [lqa_pkg::CAP_W-1:0]        csr_wdata,  // capacity
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lqa_pkg::CMD_W-1:0]        req_tuser,  // command
   input  logic [lqa_pkg::REQ_TDATA_W-1:0]  req_tdata,  // push_value
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lqa_pkg::STAT_W-1:0]       rsp_tuser,  // status
   // popped_value, occupancy, sum_remaining, sum_exited, product_remaining
   output logic [lqa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lqa_pkg::*;

   // command and status between controller and datapath
   lqa_cmd_type  dp_cmd;
   lqa_stat_type dp_stat;

   // sequencing of push, pop and report walk
   lqa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   // storage, counters, sums, product and the result register
   lqa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### sv/lqa_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lqa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lqa_ctrl.sv
// controller state machine for the linear queue with aggregates
// depends on lqa_pkg
module lqa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lqa_pkg::CMD_W-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  lqa_pkg::lqa_stat_type      dp_stat,
   output lqa_pkg::lqa_cmd_type       dp_cmd
);
   import lqa_pkg::*;

   lqa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // new work only when idle and the result slot is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_PUSH: begin
                     dp_cmd.out_load = 1'b1;
                     if (dp_stat.full) begin
                        dp_cmd.out_status = STAT_OVERFLOW;
                     end else begin
                        dp_cmd.write_en = 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (dp_stat.empty) begin
                        dp_cmd.out_load   = 1'b1;
                        dp_cmd.out_status = STAT_UNDERFLOW;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  CMD_REPORT: begin
                     if (dp_stat.empty) begin
                        dp_cmd.out_load = 1'b1;
                        dp_cmd.out_src  = SRC_ONE;
                     end else begin
                        dp_cmd.walk_init = 1'b1;
                        state_in         = ST_WALK;
                     end
                  end
                  default: begin
                     dp_cmd.out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            dp_cmd.pop_commit = 1'b1;
            dp_cmd.out_load   = 1'b1;
            dp_cmd.out_src    = SRC_POP;
            state_in          = ST_IDLE;
         end
         ST_WALK: begin
            dp_cmd.walk_step = 1'b1;
            dp_cmd.rd_walk   = 1'b1;
            if (dp_stat.walk_last) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_src  = SRC_PROD;
               state_in        = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

endmodule

### sv/lqa_dp.sv
// datapath: slot store, counters, running sums, product walk, result register
// depends on lqa_pkg and lqa_ram
module lqa_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lqa_pkg::CAP_W-1:0]        csr_wdata,
   input  logic [lqa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  lqa_pkg::lqa_cmd_type             dp_cmd,
   output lqa_pkg::lqa_stat_type            dp_stat,
   output logic [lqa_pkg::STAT_W-1:0]       rsp_tuser,
   output logic [lqa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lqa_pkg::*;

   logic [CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  wcount_ff, wcount_in;
   logic [CNT_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]  walk_next;
   logic [DATA_W-1:0] rem_sum_ff, rem_sum_in;
   logic [DATA_W-1:0] exit_sum_ff, exit_sum_in;
   logic [DATA_W-1:0] prod_ff, prod_in, prod_next;
   logic [DATA_W-1:0] push_value;
   logic [DATA_W-1:0] rd_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [LIM_W-1:0]  limit, cap_ext, depth_ext, wcount_ext;
   logic [CNT_W-1:0]  occ_full;

   // result register
   logic [STAT_W-1:0] status_ff;
   logic [DATA_W-1:0] popped_ff, sum_rem_ff, sum_exit_ff, product_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic [DATA_W-1:0] popped_sel, product_sel;

   assign push_value = req_tdata[DATA_W-1:0];

   lqa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (dp_cmd.write_en),
      .wr_addr (wcount_ff[ADDR_W-1:0]),
      .wr_data (push_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign walk_next = walk_idx_ff + CNT_W'(1);
   assign rd_addr   = dp_cmd.rd_walk ? walk_next[ADDR_W-1:0] : head_ff[ADDR_W-1:0];

   // push limit saturates at the store depth
   assign cap_ext    = LIM_W'(capacity_ff);
   assign depth_ext  = LIM_W'(DEPTH);
   assign wcount_ext = LIM_W'(wcount_ff);
   assign limit      = (cap_ext > depth_ext) ? depth_ext : cap_ext;

   assign dp_stat.full      = (wcount_ext >= limit);
   assign dp_stat.empty     = (head_ff >= wcount_ff);
   assign dp_stat.walk_last = (walk_next == wcount_ff);

   assign prod_next = prod_ff * rd_data;

   always_comb begin
      head_in     = head_ff;
      wcount_in   = wcount_ff;
      rem_sum_in  = rem_sum_ff;
      exit_sum_in = exit_sum_ff;
      walk_idx_in = walk_idx_ff;
      prod_in     = prod_ff;
      if (dp_cmd.write_en) begin
         wcount_in  = wcount_ff + CNT_W'(1);
         rem_sum_in = rem_sum_ff + push_value;
      end
      if (dp_cmd.pop_commit) begin
         head_in     = head_ff + CNT_W'(1);
         rem_sum_in  = rem_sum_ff - rd_data;
         exit_sum_in = exit_sum_ff + rd_data;
      end
      if (dp_cmd.walk_init) begin
         walk_idx_in = head_ff;
         prod_in     = DATA_W'(1);
      end
      if (dp_cmd.walk_step) begin
         walk_idx_in = walk_next;
         prod_in     = prod_next;
      end
   end

   assign occ_full = wcount_in - head_in;

   always_comb begin
      popped_sel  = '0;
      product_sel = '0;
      case (dp_cmd.out_src)
         SRC_POP:  popped_sel  = rd_data;
         SRC_ONE:  product_sel = DATA_W'(1);
         SRC_PROD: product_sel = prod_next;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         wcount_ff   <= '0;
         rem_sum_ff  <= '0;
         exit_sum_ff <= '0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         head_ff     <= head_in;
         wcount_ff   <= wcount_in;
         rem_sum_ff  <= rem_sum_in;
         exit_sum_ff <= exit_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      prod_ff     <= prod_in;
      if (dp_cmd.out_load) begin
         status_ff   <= dp_cmd.out_status;
         popped_ff   <= popped_sel;
         occ_ff      <= OCC_W'(occ_full);
         sum_rem_ff  <= rem_sum_in;
         sum_exit_ff <= exit_sum_in;
         product_ff  <= product_sel;
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = RSP_TDATA_W'({product_ff, sum_exit_ff, sum_rem_ff, occ_ff, popped_ff});

endmodule

### sv/lqa_checker.sv
// port-level checks for the linear queue with aggregates, bound to the top level
// depends on lqa_pkg and linear_queue_with_aggregates_assert.svh
module lqa_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [lqa_pkg::STAT_W-1:0]       rsp_tuser,
   input  logic [lqa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lqa_pkg::*;
`include "linear_queue_with_aggregates_assert.svh"

   logic [DATA_W-1:0]               popped;
   logic [OCC_W-1:0]                occ;
   logic [DATA_W-1:0]               product;
   logic [STAT_W+RSP_TDATA_W:0]     rsp_word;
   logic                            pop_zero, occ_zero, prod_zero;
   logic                            rsp_ovf, rsp_unf, rsp_stall, req_xfer;

   assign popped  = rsp_tdata[DATA_W-1:0];
   assign occ     = rsp_tdata[DATA_W +: OCC_W];
   assign product = rsp_tdata[3*DATA_W + OCC_W +: DATA_W];

   assign pop_zero  = (popped == '0);
   assign occ_zero  = (occ == '0);
   assign prod_zero = (product == '0);

   // valid, status and payload together, held while the receiver stalls
   assign rsp_word  = {rsp_tvalid, rsp_tuser, rsp_tdata};
   assign rsp_ovf   = rsp_tvalid && (rsp_tuser == STAT_OVERFLOW);
   assign rsp_unf   = rsp_tvalid && (rsp_tuser == STAT_UNDERFLOW);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_xfer  = req_tvalid && req_tready;

   `LQA_ASSERT_NEXT(a_reset_no_rsp, clock, 1'b0, reset, !rsp_tvalid, "result after reset")
   `LQA_ASSERT_IMPL(a_ovf_zero, clock, reset, rsp_ovf, pop_zero && prod_zero, "overflow with data")
   `LQA_ASSERT_IMPL(a_unf_empty, clock, reset, rsp_unf, occ_zero && pop_zero, "underflow with data")
   `LQA_ASSERT_IMPL(a_one_in_flight, clock, reset, rsp_stall, !req_xfer, "transfer in a stall")
   `LQA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "stalled result changed")

endmodule

bind linear_queue_with_aggregates lqa_checker u_lqa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/linear_queue_with_aggregates_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for linear_queue_with_aggregates: a queue mirror predicts each
// result from the accepted requests and compares it field by field; depends on lqa_pkg
module linear_queue_with_aggregates_tb;
   import lqa_pkg::*;

   // the spare command code the block has to answer without touching its state
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int               CLK_HALF  = 10;
   localparam int               LONG_HOLD = 400;

   // result payload as it lies in rsp_tdata, highest field first
   typedef struct packed {
      logic [DATA_W-1:0] product;
      logic [DATA_W-1:0] exited;
      logic [DATA_W-1:0] remaining;
      logic [OCC_W-1:0]  occupancy;
      logic [DATA_W-1:0] popped;
   } rsp_fields_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      rsp_fields_type    fields;
   } queue_result_type;

   // mirror of the queue: slot contents, counters, sums and the results still owed
   class queue_mirror_type;
      logic [DATA_W-1:0] slots [DEPTH];
      int unsigned       head_index;
      int unsigned       write_count;
      logic [DATA_W-1:0] remaining_sum;
      logic [DATA_W-1:0] exited_sum;
      logic [CAP_W-1:0]  capacity;
      queue_result_type  owed_results[$];
      int                error_count;

      function new();
         head_index    = 0;
         write_count   = 0;
         remaining_sum = '0;
         exited_sum    = '0;
         capacity      = CAP_RESET;
         error_count   = 0;
      endfunction

      // work out what one accepted request returns and advance the mirror
      function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
         queue_result_type res;
         int unsigned      limit;
         int unsigned      idx;
         res = '0;
         res.status = STAT_OK;
         limit = (capacity > DEPTH) ? DEPTH : capacity;
         case (cmd)
            CMD_PUSH: begin
               if (write_count >= limit) begin
                  res.status = STAT_OVERFLOW;
               end else begin
                  slots[write_count] = value;
                  write_count++;
                  remaining_sum = remaining_sum + value;
               end
            end
            CMD_POP: begin
               if (head_index >= write_count) begin
                  res.status = STAT_UNDERFLOW;
               end else begin
                  res.fields.popped = slots[head_index];
                  head_index++;
                  remaining_sum = remaining_sum - res.fields.popped;
                  exited_sum    = exited_sum + res.fields.popped;
               end
            end
            CMD_REPORT: begin
               res.fields.product = 1;
               for (idx = head_index; idx < write_count; idx++)
                  res.fields.product = res.fields.product * slots[idx];
            end
            default: ;
         endcase
         res.fields.occupancy = OCC_W'(write_count - head_index);
         res.fields.remaining = remaining_sum;
         res.fields.exited    = exited_sum;
         owed_results.push_back(res);
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(logic [STAT_W-1:0] status, logic [RSP_TDATA_W-1:0] tdata);
         queue_result_type want;
         rsp_fields_type   got;
         if (owed_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual status %h data %h",
                     $time, status, tdata);
            error_count++;
            return;
         end
         want = owed_results.pop_front();
         got  = rsp_fields_type'(tdata);
         compare_field("status", DATA_W'(want.status), DATA_W'(status));
         compare_field("popped_value", want.fields.popped, got.popped);
         compare_field("occupancy", DATA_W'(want.fields.occupancy), DATA_W'(got.occupancy));
         compare_field("sum_remaining", want.fields.remaining, got.remaining);
         compare_field("sum_exited", want.fields.exited, got.exited);
         compare_field("product_remaining", want.fields.product, got.product);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CAP_W-1:0]       csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [CMD_W-1:0]       req_tuser;   // command
   logic [REQ_TDATA_W-1:0] req_tdata;   // push_value
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [STAT_W-1:0]      rsp_tuser;   // status
   // popped_value, occupancy, sum_remaining, sum_exited, product_remaining
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   queue_mirror_type queue_model;
   bit               idle_on;        // random idling on both sides
   int               hold_request;   // long receiver hold-off asked by the stimulus

   linear_queue_with_aggregates u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // offer one request, optionally after a gap, and wait for its transfer;
   // called and returning at a rising edge, tvalid stays high if the next item follows at once
   task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 7) == 0)
         gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'(value);
      do @(posedge clock); while (!req_tready);
      queue_model.note_request(cmd, value);
   endtask

   // sender stops and waits for every owed result, then lets the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (queue_model.owed_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // capacity write while the block is idle; lands at the next rising edge
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      queue_model.capacity = value;
   endtask

   // mostly full-range values, some small ones so products stay non-trivial, some extremes
   function automatic logic [DATA_W-1:0] pick_value();
      int small_val;
      case ($urandom_range(0, 3))
         0, 1: pick_value = $urandom;
         2: begin
            small_val  = $urandom_range(0, 6) - 3;
            pick_value = DATA_W'(small_val);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: pick_value = 32'h0000_0000;
               1: pick_value = 32'h0000_0001;
               2: pick_value = 32'hFFFF_FFFF;
               3: pick_value = 32'h7FFF_FFFF;
               default: pick_value = 32'h8000_0000;
            endcase
         end
      endcase
   endfunction

   // push share given in percent; the rest split between pop, report and the spare code
   function automatic logic [CMD_W-1:0] pick_command(int push_pct);
      int roll;
      int rest;
      roll = $urandom_range(0, 99);
      rest = 100 - push_pct;
      if (roll < push_pct)
         pick_command = CMD_PUSH;
      else if (roll < push_pct + rest * 6 / 10)
         pick_command = CMD_POP;
      else if (roll < push_pct + rest * 9 / 10)
         pick_command = CMD_REPORT;
      else
         pick_command = CMD_SPARE;
   endfunction

   // one setting of capacity, then random traffic, then a full drain
   task automatic run_phase(input logic [CAP_W-1:0] cap, input int count, input int push_pct);
      int n;
      write_capacity(cap);
      for (n = 0; n < count; n++)
         offer_request(pick_command(push_pct), pick_value());
      drain_results();
   endtask

   // receiver: check every result transfer, then choose the next tready
   initial begin : receiver
      int stall_left;
      bit hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            queue_model.check_result(rsp_tuser, rsp_tdata);
         if (hold_request > 0 && !hold_taken) begin
            stall_left = hold_request;
            hold_taken = 1'b1;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // main stimulus
   initial begin : stimulus
      queue_model  = new();
      idle_on      = 1'b1;
      hold_request = 0;
      clock        = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tuser    = CMD_PUSH;
      req_tdata    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue corner cases, wrapping sums and a zero in the walk under the reset capacity
      offer_request(CMD_REPORT, 32'h0);           // product of nothing is one
      offer_request(CMD_POP, 32'hDEAD_BEEF);      // underflow, value ignored
      offer_request(CMD_SPARE, 32'h1234_5678);
      offer_request(CMD_PUSH, 32'h7FFF_FFFF);
      offer_request(CMD_PUSH, 32'h8000_0000);     // sum reaches all ones, so the next push wraps it
      offer_request(CMD_PUSH, 32'hFFFF_FFFF);
      offer_request(CMD_PUSH, 32'h0000_0000);
      offer_request(CMD_REPORT, 32'h0);           // zero in the walk
      offer_request(CMD_POP, 32'h0);
      offer_request(CMD_REPORT, 32'h0);
      offer_request(CMD_POP, 32'h0);
      offer_request(CMD_POP, 32'h0);
      offer_request(CMD_POP, 32'h0);
      offer_request(CMD_POP, 32'h0);              // underflow after draining
      offer_request(CMD_PUSH, 32'h5555_5555);
      offer_request(CMD_PUSH, 32'hAAAA_AAAA);
      offer_request(CMD_PUSH, 32'h0000_0003);
      offer_request(CMD_REPORT, 32'h0);
      offer_request(CMD_SPARE, 32'hFFFF_FFFF);
      offer_request(CMD_POP, 32'h0);
      drain_results();

      // capacity zero: every push overflows
      run_phase(8'd0, 100, 45);
      // capacity below the pushes already made
      run_phase(8'd1, 80, 45);
      run_phase(8'd40, 250, 50);
      // long receiver hold-off so a waiting result stalls the request side
      hold_request = LONG_HOLD;
      run_phase(8'd80, 300, 50);
      // capacity beyond the store saturates at its depth, heavy pushing to fill it
      run_phase(8'd255, 350, 70);
      run_phase(8'd128, 300, 40);
      // last part without idling
      idle_on = 1'b0;
      run_phase(8'd7, 300, 40);

      repeat (20) @(posedge clock);
      if (queue_model.error_count == 0 && queue_model.owed_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
